@@ design/lc3b_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3b datapath package
// Control word field positions, memory latency and shared types.
// ----------------------------------------------------------------------------
package lc3b_pkg;

  localparam int unsigned MemLatency = 5;
  localparam logic [3:0] MemReadyCount = 4'(MemLatency - 1);
  localparam logic [15:0] StartAddrReset = 16'h3000;
  localparam logic [2:0] LinkReg = 3'd7;

  typedef enum logic [1:0] {
    COND_NONE  = 2'd0,
    COND_READY = 2'd1,
    COND_BEN   = 2'd2,
    COND_ADDR  = 2'd3
  } cond_e;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_AND  = 2'd1,
    ALU_XOR  = 2'd2,
    ALU_PASS = 2'd3
  } aluk_e;

  typedef enum logic [1:0] {
    PCMUX_INC   = 2'd0,
    PCMUX_BUS   = 2'd1,
    PCMUX_ADDER = 2'd2,
    PCMUX_KEEP  = 2'd3
  } pcmux_e;

  typedef enum logic [1:0] {
    SHF_LEFT  = 2'd0,
    SHF_RIGHT = 2'd1,
    SHF_NONE  = 2'd2,
    SHF_ARITH = 2'd3
  } shf_e;

  typedef enum logic [1:0] {
    ADDR2_ZERO  = 2'd0,
    ADDR2_OFF6  = 2'd1,
    ADDR2_OFF9  = 2'd2,
    ADDR2_OFF11 = 2'd3
  } addr2_e;

  typedef struct packed {
    logic        ird;
    cond_e       cond;
    logic [5:0]  j;
    logic        ld_mar;
    logic        ld_mdr;
    logic        ld_ir;
    logic        ld_ben;
    logic        ld_reg;
    logic        ld_cc;
    logic        ld_pc;
    logic        drive_pc;
    logic        drive_mdr;
    logic        drive_alu;
    logic        drive_marmux;
    logic        drive_shf;
    pcmux_e      pcmux;
    logic        drmux;
    logic        sr1mux;
    logic        addr1mux;
    addr2_e      addr2mux;
    logic        marmux;
    aluk_e       aluk;
    logic        mio_en;
    logic        r_w;
    logic        word_op;
    logic        lshf1;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] bus;
    logic [15:0] adder;
  } dp_t;

endpackage
`default_nettype wire

@@ design/lc3b_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3b execute logic
// Bus drivers: MARMUX (address adder or trap vector), PC, ALU, shifter and MDR path, with gate priority.
// ----------------------------------------------------------------------------
module lc3b_exec import lc3b_pkg::*; (
  input  var ctrl_t       ctrl_i,
  input  wire  [15:0]     pc_i,
  input  wire  [15:0]     ir_i,
  input  wire  [15:0]     mar_i,
  input  wire  [15:0]     mdr_i,
  input  wire  [15:0]     sr1_i,
  input  wire  [15:0]     sr2_i,
  input  wire  [15:0]     shsrc_i,
  output dp_t             dp_o
);

  logic [15:0] a1, a2, adder, alu_b, alu, shf, mdrv;
  logic [31:0] ext;

  always_comb begin
    a1 = ctrl_i.addr1mux ? sr1_i : pc_i;
    unique case (ctrl_i.addr2mux)
      ADDR2_OFF6:  a2 = {{10{ir_i[5]}}, ir_i[5:0]};
      ADDR2_OFF9:  a2 = {{7{ir_i[8]}}, ir_i[8:0]};
      ADDR2_OFF11: a2 = {{5{ir_i[10]}}, ir_i[10:0]};
      default:     a2 = 16'd0;
    endcase
    if (ctrl_i.lshf1) a2 = {a2[14:0], 1'b0};
    adder = a1 + a2;

    alu_b = ir_i[5] ? {{11{ir_i[4]}}, ir_i[4:0]} : sr2_i;
    unique case (ctrl_i.aluk)
      ALU_ADD:  alu = sr1_i + alu_b;
      ALU_AND:  alu = sr1_i & alu_b;
      ALU_XOR:  alu = sr1_i ^ alu_b;
      default:  alu = sr1_i;
    endcase

    ext = {{16{shsrc_i[15]}}, shsrc_i};
    unique case (shf_e'(ir_i[5:4]))
      SHF_LEFT:  shf = shsrc_i << ir_i[3:0];
      SHF_RIGHT: shf = shsrc_i >> ir_i[3:0];
      SHF_ARITH: shf = 16'(ext >> ir_i[3:0]);
      default:   shf = 16'd0;
    endcase

    if (ctrl_i.word_op) mdrv = mdr_i;
    else if (mar_i[0]) mdrv = {{8{mdr_i[15]}}, mdr_i[15:8]};
    else mdrv = {{8{mdr_i[7]}}, mdr_i[7:0]};

    dp_o.adder = adder;
    priority if (ctrl_i.drive_marmux)
      dp_o.bus = ctrl_i.marmux ? adder : {7'd0, ir_i[7:0], 1'b0};
    else if (ctrl_i.drive_pc)  dp_o.bus = pc_i;
    else if (ctrl_i.drive_alu) dp_o.bus = alu;
    else if (ctrl_i.drive_shf) dp_o.bus = shf;
    else if (ctrl_i.drive_mdr) dp_o.bus = mdrv;
    else dp_o.bus = 16'd0;
  end

endmodule
`default_nettype wire

@@ design/lc3b_microcoded_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3b microcoded datapath
// Output: result registered on the edge that accepts the control word.
// Throughput: one control word per cycle, stalled by out_ready low or cfg_valid.
// Reset: PC to 16'h3000, flags to Z, registers and counters to zero.
// ----------------------------------------------------------------------------
module lc3b_microcoded_datapath import lc3b_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [15:0]  start_address_i,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [34:0]  control_word_i,
  input  wire  [15:0]  mem_read_data_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [5:0]   next_state_o,
  output logic [15:0]  bus_value_o,
  output logic [15:0]  pc_value_o,
  output logic [14:0]  read_word_address_o,
  output logic [14:0]  write_word_address_o,
  output logic [15:0]  write_data_o,
  output logic         write_low_o,
  output logic         write_high_o
);

  ctrl_t       ctrl;
  dp_t         dp;
  logic [15:0] pc_q, ir_q, mar_q, mdr_q;
  logic [15:0] pc_d, mar_d, mdr_d;
  logic        n_q, z_q, p_q, ben_q, rdy_q;
  logic [3:0]  cnt_q, cnt_inc;
  logic [15:0] gpr_q [8];
  logic [5:0]  ns;
  logic        wlo, whi, fire;
  logic [2:0]  dr;

  assign ctrl       = ctrl_t'(control_word_i);
  assign in_ready_o = (!out_valid_o || out_ready_i) && !cfg_valid_i;
  assign cfg_ready_o = 1'b1;
  assign fire       = in_valid_i && in_ready_o;
  assign dr         = ctrl.drmux ? LinkReg : ir_q[11:9];
  assign cnt_inc    = cnt_q + 4'(ctrl.mio_en);

  lc3b_exec u_exec (
    .ctrl_i  (ctrl),
    .pc_i    (pc_q),
    .ir_i    (ir_q),
    .mar_i   (mar_q),
    .mdr_i   (mdr_q),
    .sr1_i   (ctrl.sr1mux ? gpr_q[ir_q[8:6]] : gpr_q[ir_q[11:9]]),
    .sr2_i   (gpr_q[ir_q[2:0]]),
    .shsrc_i (gpr_q[ir_q[8:6]]),
    .dp_o    (dp)
  );

  always_comb begin
    if (ctrl.ird) ns = {2'b00, ir_q[15:12]};
    else begin
      unique case (ctrl.cond)
        COND_READY: ns = ctrl.j | {4'd0, rdy_q, 1'b0};
        COND_BEN:   ns = ctrl.j | {3'd0, ben_q, 2'b00};
        COND_ADDR:  ns = ctrl.j | {5'd0, ir_q[11]};
        default:    ns = ctrl.j;
      endcase
    end
    wlo = 1'b0;
    whi = 1'b0;
    if (ctrl.mio_en && ctrl.r_w && rdy_q) begin
      wlo = ctrl.word_op || !mar_q[0];
      whi = ctrl.word_op || mar_q[0];
    end
    mar_d = ctrl.ld_mar ? dp.bus : mar_q;
    mdr_d = mdr_q;
    if (ctrl.ld_mdr) begin
      if (!ctrl.mio_en) begin
        if (ctrl.word_op) mdr_d = dp.bus;
        else if (mar_q[0]) mdr_d = {dp.bus[7:0], 8'd0};
        else mdr_d = {8'd0, dp.bus[7:0]};
      end else if (!ctrl.r_w && rdy_q) begin
        mdr_d = mem_read_data_i;
      end
    end
    pc_d = pc_q;
    if (ctrl.ld_pc) begin
      unique case (ctrl.pcmux)
        PCMUX_INC:   pc_d = pc_q + 16'd2;
        PCMUX_BUS:   pc_d = dp.bus;
        PCMUX_ADDER: pc_d = dp.adder;
        default:     pc_d = pc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StartAddrReset;
      ir_q <= '0;
      mar_q <= '0;
      mdr_q <= '0;
      n_q <= 1'b0;
      z_q <= 1'b1;
      p_q <= 1'b0;
      ben_q <= 1'b0;
      rdy_q <= 1'b0;
      cnt_q <= '0;
      for (int i = 0; i < 8; i++) gpr_q[i] <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) pc_q <= start_address_i;
      else if (fire) pc_q <= pc_d;
      if (fire) begin
        mar_q <= mar_d;
        mdr_q <= mdr_d;
        if (ctrl.ld_ir) ir_q <= dp.bus;
        if (ctrl.ld_ben)
          ben_q <= (ir_q[11] & n_q) | (ir_q[10] & z_q) | (ir_q[9] & p_q);
        if (ctrl.ld_reg) gpr_q[dr] <= dp.bus;
        if (ctrl.ld_cc) begin
          n_q <= dp.bus[15];
          z_q <= dp.bus == 16'd0;
          p_q <= !dp.bus[15] && dp.bus != 16'd0;
        end
        if (cnt_inc > MemReadyCount) begin
          cnt_q <= '0;
          rdy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_inc;
          if (cnt_inc == MemReadyCount) rdy_q <= 1'b1;
        end
      end
      if (fire) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_state_o         <= ns;
      bus_value_o          <= dp.bus;
      pc_value_o           <= pc_d;
      read_word_address_o  <= mar_d[15:1];
      write_word_address_o <= (wlo || whi) ? mar_q[15:1] : 15'd0;
      write_data_o         <= (wlo || whi) ? mdr_q : 16'd0;
      write_low_o          <= wlo;
      write_high_o         <= whi;
    end
  end

endmodule
`default_nettype wire

@@ bench/lc3b_microcoded_datapath_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LC-3b microcoded datapath testbench
// Drives control words and memory data under random flow control, predicts
// each microcycle result from a local model of the datapath state and checks
// every output transfer in order. Walks several start addresses.
// ----------------------------------------------------------------------------
module lc3b_microcoded_datapath_test import lc3b_pkg::*; ();

  localparam int HoldCycles = 60;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [15:0] start_address;
  logic        in_valid, in_ready;
  logic [34:0] control_word;
  logic [15:0] mem_read_data;
  logic        out_valid, out_ready;
  logic [5:0]  next_state;
  logic [15:0] bus_value, pc_value, write_data;
  logic [14:0] read_word_address, write_word_address;
  logic        write_low, write_high;

  lc3b_microcoded_datapath dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .start_address_i(start_address),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .control_word_i(control_word), .mem_read_data_i(mem_read_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .next_state_o(next_state), .bus_value_o(bus_value), .pc_value_o(pc_value),
    .read_word_address_o(read_word_address), .write_word_address_o(write_word_address),
    .write_data_o(write_data), .write_low_o(write_low), .write_high_o(write_high)
  );

  typedef struct packed {
    logic [5:0]  next_state;
    logic [15:0] bus, pc;
    logic [14:0] rd_addr, wr_addr;
    logic [15:0] wr_data;
    logic        wlo, whi;
  } cycle_result_t;

  cycle_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int rx_wait = 0;
  logic rx_fire = 1'b0;
  bit holding = 0;
  bit stall_mode = 1;
  event hold_go;

  // datapath model
  logic [15:0] m_pc, m_ir, m_mar, m_mdr;
  logic        m_n, m_z, m_p, m_ben, m_ready;
  logic [3:0]  m_count;
  logic [15:0] m_regs[8];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("lc3b_microcoded_datapath: mismatch");
      $finish;
    end
  end

  task automatic model_reset(input logic [15:0] sa);
    m_pc = sa; m_ir = 0; m_mar = 0; m_mdr = 0;
    m_n = 0; m_z = 1; m_p = 0; m_ben = 0; m_ready = 0; m_count = 0;
    for (int i = 0; i < 8; i++) m_regs[i] = 0;
  endtask

  function automatic logic [15:0] sr1_of(ctrl_t c);
    return c.sr1mux ? m_regs[m_ir[8:6]] : m_regs[m_ir[11:9]];
  endfunction

  function automatic logic [15:0] address_sum(ctrl_t c);
    logic [15:0] a1, a2;
    a1 = c.addr1mux ? sr1_of(c) : m_pc;
    case (c.addr2mux)
      ADDR2_OFF6:  a2 = {{10{m_ir[5]}}, m_ir[5:0]};
      ADDR2_OFF9:  a2 = {{7{m_ir[8]}}, m_ir[8:0]};
      ADDR2_OFF11: a2 = {{5{m_ir[10]}}, m_ir[10:0]};
      default: a2 = 0;
    endcase
    if (c.lshf1) a2 = a2 << 1;
    return a1 + a2;
  endfunction

  function automatic logic [15:0] alu_of(ctrl_t c);
    logic [15:0] a, b;
    a = sr1_of(c);
    b = m_ir[5] ? {{11{m_ir[4]}}, m_ir[4:0]} : m_regs[m_ir[2:0]];
    case (c.aluk)
      ALU_ADD: return a + b;
      ALU_AND: return a & b;
      ALU_XOR: return a ^ b;
      default: return a;
    endcase
  endfunction

  function automatic logic [15:0] shift_of();
    logic [15:0] sr;
    sr = m_regs[m_ir[8:6]];
    case (shf_e'(m_ir[5:4]))
      SHF_LEFT:  return sr << m_ir[3:0];
      SHF_RIGHT: return sr >> m_ir[3:0];
      SHF_ARITH: return $signed(sr) >>> m_ir[3:0];
      default:   return 0;
    endcase
  endfunction

  task automatic predict_cycle(input logic [34:0] cw, input logic [15:0] mem);
    ctrl_t c;
    cycle_result_t r;
    logic [15:0] bus, npc, nmar, nmdr, ir;
    logic        wlo, whi;
    c = ctrl_t'(cw);
    ir = m_ir;
    if (c.ird) r.next_state = {2'b0, ir[15:12]};
    else case (c.cond)
      COND_READY: r.next_state = c.j | {4'b0, m_ready, 1'b0};
      COND_BEN:   r.next_state = c.j | {3'b0, m_ben, 2'b0};
      COND_ADDR:  r.next_state = c.j | {5'b0, ir[11]};
      default:    r.next_state = c.j;
    endcase
    if (c.drive_marmux) bus = c.marmux ? address_sum(c) : {7'b0, ir[7:0], 1'b0};
    else if (c.drive_pc) bus = m_pc;
    else if (c.drive_alu) bus = alu_of(c);
    else if (c.drive_shf) bus = shift_of();
    else if (c.drive_mdr)
      bus = c.word_op ? m_mdr
          : (m_mar[0] ? {{8{m_mdr[15]}}, m_mdr[15:8]} : {{8{m_mdr[7]}}, m_mdr[7:0]});
    else bus = 0;
    wlo = 0; whi = 0;
    if (c.mio_en && c.r_w && m_ready) begin
      if (c.word_op) begin wlo = 1; whi = 1; end
      else if (m_mar[0]) whi = 1;
      else wlo = 1;
    end
    npc = m_pc; nmar = m_mar; nmdr = m_mdr;
    if (c.ld_mar) nmar = bus;
    if (c.ld_mdr) begin
      if (!c.mio_en) nmdr = c.word_op ? bus : (m_mar[0] ? {bus[7:0], 8'b0} : {8'b0, bus[7:0]});
      else if (!c.r_w && m_ready) nmdr = mem;
    end
    if (c.ld_pc) case (c.pcmux)
      PCMUX_INC:   npc = m_pc + 16'd2;
      PCMUX_BUS:   npc = bus;
      PCMUX_ADDER: npc = address_sum(c);
      default: ;
    endcase
    if (c.ld_ben) m_ben = (ir[11] & m_n) | (ir[10] & m_z) | (ir[9] & m_p);
    if (c.ld_reg) m_regs[c.drmux ? LinkReg : ir[11:9]] = bus;
    if (c.ld_cc) begin
      m_n = bus[15]; m_z = (bus == 0); m_p = !bus[15] && bus != 0;
    end
    if (c.ld_ir) m_ir = bus;
    if (c.mio_en) m_count = m_count + 4'd1;
    if (m_count == MemReadyCount) m_ready = 1;
    if (m_count > MemReadyCount) begin m_count = 0; m_ready = 0; end
    r.bus = bus; r.pc = npc; r.rd_addr = nmar[15:1];
    r.wr_addr = (wlo | whi) ? m_mar[15:1] : 15'd0;
    r.wr_data = (wlo | whi) ? m_mdr : 16'd0;
    r.wlo = wlo; r.whi = whi;
    m_pc = npc; m_mar = nmar; m_mdr = nmdr;
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("error at cycle %0d: %s got %h want %h", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    cycle_result_t e;
    rx_fire <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) report("unexpected transfer", 16'd0, 16'd0);
      else begin
        e = expected_q.pop_front();
        if (next_state !== e.next_state) report("next_state", next_state, e.next_state);
        if (bus_value !== e.bus) report("bus_value", bus_value, e.bus);
        if (pc_value !== e.pc) report("pc_value", pc_value, e.pc);
        if (read_word_address !== e.rd_addr) report("read_addr", read_word_address, e.rd_addr);
        if (write_word_address !== e.wr_addr)
          report("write_addr", write_word_address, e.wr_addr);
        if (write_data !== e.wr_data) report("write_data", write_data, e.wr_data);
        if (write_low !== e.wlo) report("write_low", write_low, e.wlo);
        if (write_high !== e.whi) report("write_high", write_high, e.whi);
      end
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(hold_go);
    holding = 1;
    repeat (HoldCycles) @(negedge clk);
    holding = 0;
  end

  // receiver: draw a wait for every transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      rx_wait = 0;
    end else begin
      if (rx_fire)
        rx_wait = stall_mode ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0) : 0;
      if (holding) out_ready <= 0;
      else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 0;
      end else out_ready <= 1;
    end
  end

  task automatic send_word(input logic [34:0] cw, input logic [15:0] mem);
    int gap;
    gap = stall_mode ? ($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; control_word <= cw; mem_read_data <= mem;
    do @(posedge clk); while (!in_ready);
    predict_cycle(cw, mem);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_start(input logic [15:0] sa);
    cfg_valid <= 1; start_address <= sa;
    do @(posedge clk); while (!cfg_ready);
    m_pc = sa;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [34:0] field(input int lsb, input logic [5:0] v);
    return 35'(v) << lsb;
  endfunction

  // a fetch/execute flavored word: random fields, in half the draws with one bus gate
  function automatic logic [34:0] rand_micro();
    logic [34:0] w;
    w = {3'($urandom), 32'($urandom)};
    if ($urandom_range(0, 1)) begin
      w[18:14] = 5'b1 << $urandom_range(0, 4);
      w[3] = $urandom_range(0, 2) == 0;
    end
    return w;
  endfunction

  task automatic test_directed();
    send_word(field(18, 1) | field(25, 1) | field(19, 1), 16'h0);
    send_word(field(19, 1) | field(12, 3), 16'h0);
    repeat (6) send_word(field(3, 1) | field(24, 1) | field(32, 1), 16'hE5A3);
    send_word(field(3, 1) | field(2, 1) | field(1, 1), 16'h0);
    send_word(field(15, 1) | field(16, 1) | field(23, 1), 16'hFFFF);
    send_word(field(17, 1) | field(23, 1), 16'h0);
    send_word(field(16, 1) | field(21, 1) | field(20, 1) | field(4, 3), 16'h0);
    send_word(field(14, 1) | field(21, 1) | field(11, 1), 16'h0);
    send_word(field(15, 1) | field(6, 1) | field(7, 3) | field(0, 1) | field(25, 1), 16'h0);
    send_word(field(34, 1) | field(22, 1), 16'hFFFF);
    send_word(field(32, 2) | field(26, 6), 16'h0);
    send_word(field(32, 3) | field(17, 1) | field(24, 1), 16'h0);
    send_word({35{1'b1}}, 16'hFFFF);
    send_word('0, 16'h0);
    send_word(field(19, 1) | field(12, 1) | field(16, 1), 16'h1234);
    send_word(field(19, 1) | field(12, 2) | field(9, 1) | field(7, 2), 16'h0);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_word(rand_micro(), 16'($urandom));
  endtask

  task automatic test_backpressure();
    stall_mode = 0;
    -> hold_go;
    test_random(40);
    stall_mode = 1;
  endtask

  initial begin
    rst_n = 0; cfg_valid = 0; start_address = 0; in_valid = 0;
    control_word = 0; mem_read_data = 0;
    model_reset(StartAddrReset);
    repeat (8) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_random(200);
    drain();
    write_start(16'h0000);
    test_random(200);
    test_backpressure();
    drain();
    write_start(16'hFFFF);
    test_random(250);
    drain();
    write_start(16'($urandom));
    stall_mode = 0;
    test_random(100);
    stall_mode = 1;
    test_random(150);
    drain();
    if (errors == 0) $display("lc3b_microcoded_datapath: match");
    else $display("lc3b_microcoded_datapath: mismatch");
    $finish;
  end

endmodule
